// ----- design/smlf_pkg.sv -----
// Package for series_mean_and_line_fit: item structs, widths and codes.
// No dependencies.
package smlf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int CNT_W = 7;
    localparam logic [31:0] MISSING_MARK = 32'hFFFF_0000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NODATA = 2'd1,
        ST_DEGEN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [11:0]        year;
        logic signed [31:0] sample_value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mean_value;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [6:0]         present_count;
        logic [1:0]         status;
    } out_item_t;

    // Divider widths: 128-bit dividend, 64-bit divisor (2 * den)
    localparam int DIV_NW = 128;
    localparam int DIV_DW = 64;

endpackage

// ----- design/smlf_mul.sv -----
// Multicycle 64x64 unsigned multiplier, one 16-bit digit of b per cycle.
// Depends on smlf_pkg.
module smlf_mul
    import smlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic          done,
    output logic [127:0]  prod
);
    logic [127:0] acc_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [79:0]  part;

    // One 64x16 partial product per cycle
    assign part = a_reg * {64'd0, b_reg[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + ({48'd0, part} << {cnt_reg[1:0], 4'd0});
            b_reg   <= b_reg >> 16;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ----- design/smlf_div.sv -----
// Restoring divider for rounded, saturated signed quotients.
// Depends on smlf_pkg.
module smlf_div
    import smlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic          neg,
    input  logic [127:0]  mag,
    input  logic [62:0]   den,
    output logic          done,
    output logic [31:0]   result
);
    logic [127:0] num_reg;
    logic [127:0] q_reg;
    logic [64:0]  rem_reg;
    logic [63:0]  d_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic         neg_reg;
    logic [64:0]  shifted;
    logic         ge;

    // One quotient bit per cycle
    assign shifted = {rem_reg[63:0], num_reg[127]};
    assign ge      = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend 2*mag + den, divisor 2*den: rounds half away from zero
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= {mag[126:0], 1'b0} + {65'd0, den};
            d_reg   <= {den, 1'b0};
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            q_reg   <= {q_reg[126:0], ge};
            rem_reg <= ge ? shifted - {1'b0, d_reg} : shifted;
        end
    end

    // Saturate into signed 32 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg[127:32] != '0 || q_reg[31:0] > 32'h8000_0000)
                result = 32'h8000_0000;
            else
                result = 32'd0 - q_reg[31:0];
        end
        else
        begin
            if (q_reg[127:31] != '0)
                result = 32'h7FFF_FFFF;
            else
                result = q_reg[31:0];
        end
    end

    assign done = done_reg;
endmodule

// ----- design/series_mean_and_line_fit.sv -----
// Top level of series_mean_and_line_fit: accumulator and result sequencer.
// Depends on smlf_pkg, smlf_mul and smlf_div.
//
// An item is taken when start is high and busy is low. A sample that is not
// last does not start the sequencer and leaves busy low. On the last sample
// the block runs a sequencer over one shared 64x64 multiplier and one
// restoring divider. A product is a launch, four 16-bit digits and done; a
// quotient is a launch, 128 bits and done. A full fit is three quotients and
// six products plus the denominator and output states. Equal years end the
// fit after the mean, two products and the denominator; no present sample
// ends it at the mean. The result then appears for one cycle with done high.
// The receiver cannot stall it, so it must take it in that cycle.
module series_mean_and_line_fit
    import smlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  in_item,
    output logic      busy,
    output logic      done,
    output out_item_t out_item
);
    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DEN, S_SLOPE,
        S_ICPT, S_OUT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [17:0]       sx_reg;
    logic signed [37:0] sy_reg;
    logic [30:0]       sxx_reg;
    logic signed [50:0] sxy_reg;
    logic [127:0]      t_reg;      // product scratch
    logic [127:0]      u_reg;
    logic [62:0]       den_reg;
    logic              nneg_reg;
    logic [127:0]      nmag_reg;
    out_item_t         out_reg;
    logic              done_reg;
    logic              step_reg;   // first cycle of a state: launch unit

    logic         mul_go, mul_done, div_go, div_done, div_neg;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p, div_mag;
    logic [62:0]  div_den;
    logic [31:0]  div_q;
    logic         accept, present;
    logic [37:0]  sy_mag;
    logic [50:0]  sxy_mag;
    logic [127:0] sxy_term;
    logic signed [128:0] diff;

    assign accept  = start && !busy;
    assign present = (in_item.sample_value != MISSING_MARK)
                     && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign sy_mag  = sy_reg[37] ? 38'd0 - sy_reg : sy_reg;
    assign sxy_mag = sxy_reg[50] ? 51'd0 - sxy_reg : sxy_reg;
    assign busy    = (state_reg != S_IDLE);
    // signed sx*sxy from the magnitude product
    assign sxy_term = sxy_reg[50] ? 128'd0 - mul_p : mul_p;
    assign diff     = $signed({1'b0, t_reg}) - $signed({1'b0, u_reg});

    smlf_mul u_mul (.clk, .rst_n, .go(mul_go), .a(mul_a), .b(mul_b),
                    .done(mul_done), .prod(mul_p));
    smlf_div u_div (.clk, .rst_n, .go(div_go), .neg(div_neg), .mag(div_mag),
                    .den(div_den), .done(div_done), .result(div_q));

    // Operand selection and launch for shared units
    always_comb
    begin
        mul_go  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_go  = 1'b0;
        div_neg = 1'b0;
        div_mag = '0;
        div_den = den_reg;
        case (state_reg)
            S_M1:
            begin   // n*sxx
                mul_a = {57'd0, cnt_reg};
                mul_b = {33'd0, sxx_reg};
            end
            S_M2:
            begin   // sx*sx
                mul_a = {46'd0, sx_reg};
                mul_b = {46'd0, sx_reg};
            end
            S_M3:
            begin   // n*|sxy|
                mul_a = {57'd0, cnt_reg};
                mul_b = {13'd0, sxy_mag};
            end
            S_M4:
            begin   // sx*|sy|
                mul_a = {46'd0, sx_reg};
                mul_b = {26'd0, sy_mag};
            end
            S_M5:
            begin   // sxx*|sy|
                mul_a = {33'd0, sxx_reg};
                mul_b = {26'd0, sy_mag};
            end
            S_M6:
            begin   // sx*|sxy|
                mul_a = {46'd0, sx_reg};
                mul_b = {13'd0, sxy_mag};
            end
            S_MEAN:
            begin
                div_neg = sy_reg[37];
                div_mag = {90'd0, sy_mag};
                div_den = {56'd0, cnt_reg};
            end
            S_SLOPE:
            begin
                div_neg = nneg_reg;
                div_mag = nmag_reg;
            end
            S_ICPT:
            begin
                div_neg = nneg_reg;
                div_mag = nmag_reg;
            end
            default: ;
        endcase
        if (step_reg)
        begin
            case (state_reg)
                S_MEAN: div_go = (cnt_reg != '0);
                S_SLOPE, S_ICPT: div_go = 1'b1;
                S_M1, S_M2, S_M3, S_M4, S_M5, S_M6: mul_go = 1'b1;
                default: ;
            endcase
        end
    end

    // Sequencer, accumulators and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            t_reg     <= '0;
            u_reg     <= '0;
            den_reg   <= '0;
            nneg_reg  <= 1'b0;
            nmag_reg  <= '0;
            out_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            step_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (present)
                        begin
                            cnt_reg <= cnt_reg + 7'd1;
                            sx_reg  <= sx_reg + 18'(in_item.year);
                            sy_reg  <= sy_reg + 38'(in_item.sample_value);
                            sxx_reg <= sxx_reg + 31'(in_item.year * in_item.year);
                            sxy_reg <= sxy_reg + 51'($signed({1'b0, in_item.year})
                                       * in_item.sample_value);
                        end
                        if (in_item.last)
                        begin
                            state_reg <= S_MEAN;
                            step_reg  <= 1'b1;
                        end
                    end
                end
                S_MEAN:
                begin
                    if (cnt_reg == '0)
                    begin
                        out_reg   <= '{32'sd0, 32'sd0, 32'sd0, 7'd0, ST_NODATA};
                        state_reg <= S_OUT;
                    end
                    else if (div_done)
                    begin
                        out_reg.mean_value    <= div_q;
                        out_reg.slope         <= '0;
                        out_reg.intercept     <= '0;
                        out_reg.present_count <= cnt_reg;
                        out_reg.status        <= ST_OK;
                        state_reg <= S_M1;
                        step_reg  <= 1'b1;
                    end
                end
                S_M1:
                    if (mul_done)
                    begin
                        t_reg <= mul_p;
                        state_reg <= S_M2;
                        step_reg <= 1'b1;
                    end
                S_M2:
                    if (mul_done)
                    begin
                        u_reg <= mul_p;
                        state_reg <= S_DEN;
                    end
                S_DEN:
                begin
                    // den = n*sxx - sx^2; always >= 0
                    den_reg <= diff[62:0];
                    if (diff <= 0)
                    begin
                        out_reg.status <= ST_DEGEN;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_M3;
                        step_reg  <= 1'b1;
                    end
                end
                S_M3:
                    if (mul_done)
                    begin
                        t_reg <= sxy_reg[50] ? 128'd0 - mul_p : mul_p;
                        state_reg <= S_M4;
                        step_reg <= 1'b1;
                    end
                S_M4:
                    if (mul_done)
                    begin
                        // num = n*sxy - sx*sy as signed 128
                        if (($signed(t_reg) - $signed(sy_reg[37] ? 128'd0 - mul_p
                             : mul_p)) < 0)
                        begin
                            nneg_reg <= 1'b1;
                            nmag_reg <= (sy_reg[37] ? 128'd0 - mul_p : mul_p) - t_reg;
                        end
                        else
                        begin
                            nneg_reg <= 1'b0;
                            nmag_reg <= t_reg - (sy_reg[37] ? 128'd0 - mul_p : mul_p);
                        end
                        state_reg <= S_SLOPE;
                        step_reg <= 1'b1;
                    end
                S_SLOPE:
                    if (div_done)
                    begin
                        out_reg.slope <= div_q;
                        state_reg <= S_M5;
                        step_reg <= 1'b1;
                    end
                S_M5:
                    if (mul_done)
                    begin
                        // signed sxx*sy
                        t_reg <= sy_reg[37] ? 128'd0 - mul_p : mul_p;
                        state_reg <= S_M6;
                        step_reg <= 1'b1;
                    end
                S_M6:
                    if (mul_done)
                    begin
                        // icpt num = sxx*sy - sx*sxy
                        if ($signed(t_reg) < $signed(sxy_term))
                        begin
                            nneg_reg <= 1'b1;
                            nmag_reg <= sxy_term - t_reg;
                        end
                        else
                        begin
                            nneg_reg <= 1'b0;
                            nmag_reg <= t_reg - sxy_term;
                        end
                        state_reg <= S_ICPT;
                        step_reg <= 1'b1;
                    end
                S_ICPT:
                    if (div_done)
                    begin
                        out_reg.intercept <= div_q;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    cnt_reg   <= '0;
                    sx_reg    <= '0;
                    sy_reg    <= '0;
                    sxx_reg   <= '0;
                    sxy_reg   <= '0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign out_item = out_reg;

    // Checks
    a_nobusy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cnt_reg == '0) else $error("sums not cleared");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES)) else $error("count overflow");
endmodule

// ----- dv/smlf_checker.sv -----
// Checker for series_mean_and_line_fit: predicts each series' fit from accepted items
// and compares every done strobe against it. Depends on smlf_pkg.
module smlf_checker
    import smlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  in_item,
    input  logic      done,
    input  out_item_t out_item,
    output int        fail_count,
    output int        fits_pending
);

    // running sums of the series in progress
    logic [6:0]         n_acc;
    logic [17:0]        sx_acc;
    logic signed [37:0] sy_acc;
    logic [30:0]        sxx_acc;
    logic signed [50:0] sxy_acc;
    out_item_t          expected_fits[$];

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endtask

    // quotient rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] round_quot(logic signed [127:0] num,
                                               logic signed [127:0] den);
        logic [129:0] mag;
        logic [129:0] d;
        logic [129:0] q;
        logic         neg;
        neg = num < 0;
        mag = neg ? 130'(-num) : 130'(num);
        d = 130'(den);
        q = ((mag << 1) + d) / (d << 1);
        if (neg)
        begin
            if (q > 130'h8000_0000) return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 130'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    task automatic take_sample(in_item_t it);
        logic signed [127:0] n;
        logic signed [127:0] sx;
        logic signed [127:0] sy;
        logic signed [127:0] sxx;
        logic signed [127:0] sxy;
        logic signed [127:0] den;
        out_item_t           fit;
        if (it.sample_value != MISSING_MARK && n_acc < MAX_SAMPLES)
        begin
            n_acc   = n_acc + 1;
            sx_acc  = sx_acc + it.year;
            sy_acc  = sy_acc + it.sample_value;
            sxx_acc = sxx_acc + 31'(it.year * it.year);
            sxy_acc = sxy_acc + 51'(longint'(it.year) * longint'(it.sample_value));
        end
        if (!it.last) return;
        n = n_acc; sx = sx_acc; sy = sy_acc; sxx = sxx_acc; sxy = sxy_acc;
        fit = '0;
        fit.present_count = n_acc;
        if (n_acc == 0)
            fit.status = ST_NODATA;
        else
        begin
            fit.mean_value = round_quot(sy, n);
            den = n * sxx - sx * sx;
            if (den <= 0)
                fit.status = ST_DEGEN;
            else
            begin
                fit.status    = ST_OK;
                fit.slope     = round_quot(n * sxy - sx * sy, den);
                fit.intercept = round_quot(sxx * sy - sx * sxy, den);
            end
        end
        expected_fits.push_back(fit);
        n_acc = 0; sx_acc = 0; sy_acc = 0; sxx_acc = 0; sxy_acc = 0;
    endtask

    task automatic check_fit(out_item_t got);
        out_item_t want;
        if (expected_fits.size() == 0)
        begin
            fail_count++;
            $display("result with no series pending at %0t", $realtime);
            return;
        end
        want = expected_fits.pop_front();
        if (got.mean_value !== want.mean_value)
            report_mismatch("mean_value", want.mean_value, got.mean_value);
        if (got.slope !== want.slope)
            report_mismatch("slope", want.slope, got.slope);
        if (got.intercept !== want.intercept)
            report_mismatch("intercept", want.intercept, got.intercept);
        if (got.present_count !== want.present_count)
            report_mismatch("present_count", want.present_count, got.present_count);
        if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
    endtask

    // watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_acc = 0; sx_acc = 0; sy_acc = 0; sxx_acc = 0; sxy_acc = 0;
            expected_fits.delete();
            fail_count = 0;
            fits_pending = 0;
        end
        else
        begin
            if (done === 1'b1)
                check_fit(out_item);
            if (start && busy === 1'b0)
                take_sample(in_item);
            fits_pending = expected_fits.size();
        end
    end

endmodule

// ----- dv/tb_series_mean_and_line_fit.sv -----
// Testbench top for series_mean_and_line_fit: drives series of samples with
// random gaps and gives the verdict. Depends on smlf_pkg and smlf_checker.
module tb_series_mean_and_line_fit;
    import smlf_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  in_item;
    logic      busy;
    logic      done;
    out_item_t out_item;
    int        fail_count;
    int        fits_pending;
    int        idle_cycles;
    int        items_sent;

    series_mean_and_line_fit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
        .busy(busy), .done(done), .out_item(out_item)
    );

    smlf_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .out_item(out_item), .fail_count(fail_count),
        .fits_pending(fits_pending)
    );

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // watchdog: cycles with no item and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 20000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [11:0] yr, logic [31:0] val, logic lst);
        int gap;
        case ($urandom_range(0, 19))
            0:       gap = $urandom_range(10, 40);
            1, 2, 3: gap = $urandom_range(1, 3);
            default: gap = 0;
        endcase
        repeat (gap)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        in_item.year = yr;
        in_item.sample_value = val;
        in_item.last = lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MISSING_MARK;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    // one series: year mode 0 full range, 1 narrow window, 2 single year
    task automatic send_series(int len, int mode);
        logic [11:0] base;
        logic [11:0] yr;
        base = $urandom_range(0, 4095);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0:       yr = $urandom_range(0, 4095);
                1:       yr = base + $urandom_range(0, 15);
                default: yr = base;
            endcase
            send_item(yr, pick_value(), i == len - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        idle_cycles = 0;
        items_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no sample present, alone and after missing ones
        send_item(12'd5, MISSING_MARK, 1'b1);
        send_item(12'd1, MISSING_MARK, 1'b0);
        send_item(12'd2, MISSING_MARK, 1'b1);
        // single sample and equal years: zero denominator
        send_item(12'hFFF, 32'h7FFF_FFFF, 1'b1);
        send_item(12'd7, 32'h8000_0000, 1'b0);
        send_item(12'd7, 32'h0001_0000, 1'b1);
        // steep slope saturates both ways
        send_item(12'd0, 32'h8000_0000, 1'b0);
        send_item(12'd1, 32'h7FFF_FFFF, 1'b1);
        send_item(12'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(12'd1, 32'h8000_0000, 1'b1);
        // extreme years with a gap
        send_item(12'd0, 32'h0000_0000, 1'b0);
        send_item(12'hFFF, MISSING_MARK, 1'b0);
        send_item(12'hFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(12'h800, 32'h0000_8000, 1'b1);
        // series longer than the sample limit
        send_series(70, 0);

        // random series, mostly short
        while (items_sent < 1200)
            send_series($urandom_range(0, 15) == 0 ? $urandom_range(20, 75)
                                                   : $urandom_range(1, 10),
                        $urandom_range(0, 5) == 0 ? 2 : $urandom_range(0, 1));
        start = 1'b0;

        while (fits_pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/smlf_pkg.sv
design/smlf_mul.sv
design/smlf_div.sv
design/series_mean_and_line_fit.sv
dv/smlf_checker.sv
dv/tb_series_mean_and_line_fit.sv
